@@ hdl/pts_pkg.sv @@
// Shared types and codes for the priority thread scheduler.
// No dependencies; used by pts_cell and priority_thread_scheduler_core.
package pts_pkg;

	localparam int SLOT_COUNT_DEF     = 16;
	localparam int PRIORITY_WIDTH_DEF = 8;
	localparam int FUNC_W             = 2;
	localparam int OUTCOME_W          = 2;

	// Request codes.
	localparam logic [FUNC_W-1:0] FUNC_CREATE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EXIT     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd2;

	// Result codes.
	localparam logic [OUTCOME_W-1:0] OUT_DONE    = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_NO_SLOT = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_EMPTY   = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_HALTED  = 2'd3;

	// Whole-queue moves applied by every cell in the same cycle.
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_POP
	} cell_cmd_t;

endpackage

@@ hdl/pts_cell.sv @@
// One ready-queue position: holds a slot index and its priority.
// Depends on pts_pkg for the queue move command.
module pts_cell #(
	parameter int SLOT_W = 4,
	parameter int PRIO_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pts_pkg::cell_cmd_t cmd,
	input  logic               left_valid,
	input  logic [SLOT_W-1:0]  left_slot,
	input  logic [PRIO_W-1:0]  left_prio,
	input  logic               right_valid,
	input  logic [SLOT_W-1:0]  right_slot,
	input  logic [PRIO_W-1:0]  right_prio,
	input  logic               tin_valid,
	input  logic               tin_placed,
	input  logic [SLOT_W-1:0]  tin_slot,
	input  logic [PRIO_W-1:0]  tin_prio,
	output logic               tout_valid,
	output logic               tout_placed,
	output logic [SLOT_W-1:0]  tout_slot,
	output logic [PRIO_W-1:0]  tout_prio,
	output logic               valid,
	output logic [SLOT_W-1:0]  slot,
	output logic [PRIO_W-1:0]  prio
);
	import pts_pkg::*;

	logic              valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PRIO_W-1:0] prio_q;
	logic              tok_valid_q;
	logic              tok_placed_q;
	logic [SLOT_W-1:0] tok_slot_q;
	logic [PRIO_W-1:0] tok_prio_q;
	logic              take;

	// The travelling item lands here once it meets an empty position or a less
	// urgent entry; from then on every later cell swaps with the carried entry.
	assign take = tin_valid && (tin_placed || !valid_q || (prio_q > tin_prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			tok_valid_q  <= 1'b0;
			tok_placed_q <= 1'b0;
		end else begin
			tok_valid_q  <= tin_valid && (take ? valid_q : 1'b1);
			tok_placed_q <= take ? 1'b1 : tin_placed;
			unique case (cmd)
				CMD_PUSH: valid_q <= left_valid;
				CMD_POP:  valid_q <= right_valid;
				default: begin
					if (take) begin
						valid_q <= 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tok_slot_q <= take ? slot_q : tin_slot;
		tok_prio_q <= take ? prio_q : tin_prio;
		unique case (cmd)
			CMD_PUSH: begin
				slot_q <= left_slot;
				prio_q <= left_prio;
			end
			CMD_POP: begin
				slot_q <= right_slot;
				prio_q <= right_prio;
			end
			default: begin
				if (take) begin
					slot_q <= tin_slot;
					prio_q <= tin_prio;
				end
			end
		endcase
	end

	assign tout_valid  = tok_valid_q;
	assign tout_placed = tok_placed_q;
	assign tout_slot   = tok_slot_q;
	assign tout_prio   = tok_prio_q;
	assign valid       = valid_q;
	assign slot        = slot_q;
	assign prio        = prio_q;

endmodule

@@ hdl/priority_thread_scheduler_core.sv @@
// Priority thread scheduler: slot bookkeeping, request sequencing and the ready queue.
// Depends on pts_pkg and pts_cell.

// A request is taken when start is high and busy is low; its result appears on done for
// one cycle and must be taken then, since the block cannot be held off. Exit, dispatch,
// a preempting create and any refused request pass from acceptance through the execute
// and report states to done. A create that joins the ready queue walks the queue one cell
// per cycle and stays in the wave state until the new entry and the entries it displaces
// have stopped travelling down the row of cells. Busy drops in the cycle done is shown,
// so the next request can be taken then.
module priority_thread_scheduler_core #(
	parameter int SLOT_COUNT     = pts_pkg::SLOT_COUNT_DEF,
	parameter int PRIORITY_WIDTH = pts_pkg::PRIORITY_WIDTH_DEF,
	localparam int SLOT_W        = $clog2(SLOT_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pts_pkg::FUNC_W-1:0]    func,
	input  logic [PRIORITY_WIDTH-1:0]     priority_req,
	output logic                          done,
	output logic [pts_pkg::OUTCOME_W-1:0] outcome,
	output logic [SLOT_W-1:0]             new_pid,
	output logic [SLOT_W-1:0]             running_pid,
	output logic                          running_valid,
	output logic                          switched
);
	import pts_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAVE,
		S_REPORT
	} state_t;

	state_t                      state_q;
	logic [FUNC_W-1:0]           func_q;
	logic [PRIORITY_WIDTH-1:0]   prio_q;
	logic [SLOT_COUNT-1:0]       used_q;
	logic [SLOT_COUNT-1:0]       exited_q;
	logic                        halted_q;
	logic                        cur_valid_q;
	logic [SLOT_W-1:0]           cur_q;
	logic [PRIORITY_WIDTH-1:0]   cur_prio_q;
	logic [SLOT_W-1:0]           free_q;
	logic                        free_any_q;
	logic                        done_q;
	logic [OUTCOME_W-1:0]        outcome_q;
	logic [SLOT_W-1:0]           new_pid_q;
	logic [SLOT_W-1:0]           running_pid_q;
	logic                        running_valid_q;
	logic                        switched_q;

	logic [SLOT_W-1:0]           free_idx;
	logic                        free_any;
	logic                        preempt;
	logic                        do_insert;
	logic                        do_push;
	logic                        do_pop;
	cell_cmd_t                   cmd;

	logic [SLOT_COUNT-1:0]       cell_valid;
	logic [SLOT_W-1:0]           cell_slot [SLOT_COUNT];
	logic [PRIORITY_WIDTH-1:0]   cell_prio [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]       tok_valid;
	logic [SLOT_COUNT-1:0]       tok_placed;
	logic [SLOT_W-1:0]           tok_slot [SLOT_COUNT];
	logic [PRIORITY_WIDTH-1:0]   tok_prio [SLOT_COUNT];

	// Lowest free slot, registered; slot use changes only in the execute state, and the report
	// state lies between that and the next request's execute state, so the register is current.
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (!used_q[k]) begin
				free_idx = SLOT_W'(k);
				free_any = 1'b1;
			end
		end
	end

	always_comb begin
		preempt   = cur_valid_q && (cur_prio_q > prio_q);
		do_insert = (state_q == S_EXEC) && !halted_q && (func_q == FUNC_CREATE) &&
			free_any_q && !preempt;
		do_push   = (state_q == S_EXEC) && !halted_q && (func_q == FUNC_CREATE) &&
			free_any_q && preempt && !exited_q[cur_q];
		do_pop    = (state_q == S_EXEC) && !halted_q && cell_valid[0] &&
			((func_q == FUNC_DISPATCH) ||
			 ((func_q == FUNC_EXIT) && cur_valid_q && (cur_q != '0)));
		if (do_push) begin
			cmd = CMD_PUSH;
		end else if (do_pop) begin
			cmd = CMD_POP;
		end else begin
			cmd = CMD_HOLD;
		end
	end

	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
		logic                      lv;
		logic [SLOT_W-1:0]         ls;
		logic [PRIORITY_WIDTH-1:0] lp;
		logic                      rv;
		logic [SLOT_W-1:0]         rs;
		logic [PRIORITY_WIDTH-1:0] rp;
		logic                      tv;
		logic                      tpl;
		logic [SLOT_W-1:0]         ts;
		logic [PRIORITY_WIDTH-1:0] tp;

		if (k == 0) begin : g_head
			// The head takes the preempted thread on a push; on an insert the new item enters at the head.
			assign lv  = 1'b1;
			assign ls  = cur_q;
			assign lp  = cur_prio_q;
			assign tv  = do_insert;
			assign tpl = 1'b0;
			assign ts  = free_q;
			assign tp  = prio_q;
		end else begin : g_body
			assign lv  = cell_valid[k-1];
			assign ls  = cell_slot[k-1];
			assign lp  = cell_prio[k-1];
			assign tv  = tok_valid[k-1];
			assign tpl = tok_placed[k-1];
			assign ts  = tok_slot[k-1];
			assign tp  = tok_prio[k-1];
		end

		if (k == SLOT_COUNT - 1) begin : g_tail
			assign rv = 1'b0;
			assign rs = '0;
			assign rp = '0;
		end else begin : g_inner
			assign rv = cell_valid[k+1];
			assign rs = cell_slot[k+1];
			assign rp = cell_prio[k+1];
		end

		pts_cell #(
			.SLOT_W (SLOT_W),
			.PRIO_W (PRIORITY_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_valid  (lv),
			.left_slot   (ls),
			.left_prio   (lp),
			.right_valid (rv),
			.right_slot  (rs),
			.right_prio  (rp),
			.tin_valid   (tv),
			.tin_placed  (tpl),
			.tin_slot    (ts),
			.tin_prio    (tp),
			.tout_valid  (tok_valid[k]),
			.tout_placed (tok_placed[k]),
			.tout_slot   (tok_slot[k]),
			.tout_prio   (tok_prio[k]),
			.valid       (cell_valid[k]),
			.slot        (cell_slot[k]),
			.prio        (cell_prio[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			func_q          <= '0;
			prio_q          <= '0;
			used_q          <= '0;
			exited_q        <= '0;
			halted_q        <= 1'b0;
			cur_valid_q     <= 1'b0;
			cur_q           <= '0;
			cur_prio_q      <= '0;
			free_q          <= '0;
			free_any_q      <= 1'b0;
			done_q          <= 1'b0;
			outcome_q       <= OUT_DONE;
			new_pid_q       <= '0;
			running_pid_q   <= '0;
			running_valid_q <= 1'b0;
			switched_q      <= 1'b0;
		end else begin
			free_q     <= free_idx;
			free_any_q <= free_any;
			done_q     <= (state_q == S_REPORT);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= func;
						prio_q  <= priority_req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					outcome_q  <= OUT_DONE;
					new_pid_q  <= '0;
					switched_q <= 1'b0;
					state_q    <= S_REPORT;
					if (halted_q) begin
						outcome_q <= OUT_HALTED;
					end else begin
						unique case (func_q)
							FUNC_CREATE: begin
								if (!free_any_q) begin
									outcome_q <= OUT_NO_SLOT;
								end else begin
									used_q[free_q]   <= 1'b1;
									exited_q[free_q] <= 1'b0;
									new_pid_q        <= free_q;
									if (preempt) begin
										// An exited thread that is preempted gives up its slot.
										if (exited_q[cur_q]) begin
											used_q[cur_q]   <= 1'b0;
											exited_q[cur_q] <= 1'b0;
										end
										cur_q      <= free_q;
										cur_prio_q <= prio_q;
										switched_q <= 1'b1;
									end else begin
										state_q <= S_WAVE;
									end
								end
							end
							FUNC_EXIT: begin
								if (cur_valid_q) begin
									if (cur_q == '0) begin
										exited_q[cur_q] <= 1'b1;
										halted_q        <= 1'b1;
										outcome_q       <= OUT_HALTED;
									end else if (cell_valid[0]) begin
										used_q[cur_q]   <= 1'b0;
										exited_q[cur_q] <= 1'b0;
										cur_q           <= cell_slot[0];
										cur_prio_q      <= cell_prio[0];
										switched_q      <= 1'b1;
									end else begin
										exited_q[cur_q] <= 1'b1;
										outcome_q       <= OUT_EMPTY;
									end
								end
							end
							FUNC_DISPATCH: begin
								if (cell_valid[0]) begin
									if (cur_valid_q && exited_q[cur_q]) begin
										used_q[cur_q]   <= 1'b0;
										exited_q[cur_q] <= 1'b0;
									end
									cur_q       <= cell_slot[0];
									cur_prio_q  <= cell_prio[0];
									cur_valid_q <= 1'b1;
									switched_q  <= 1'b1;
								end else begin
									outcome_q <= OUT_EMPTY;
								end
							end
							default: begin
								outcome_q <= OUT_DONE;
							end
						endcase
					end
				end
				S_WAVE: begin
					// The insert is finished once no travelling entry, new or displaced, is still moving.
					if (!(|tok_valid)) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					running_pid_q   <= cur_valid_q ? cur_q : '0;
					running_valid_q <= cur_valid_q;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign outcome       = outcome_q;
	assign new_pid       = new_pid_q;
	assign running_pid   = running_pid_q;
	assign running_valid = running_valid_q;
	assign switched      = switched_q;

endmodule
